FILE: rtl/mpfb_pkg.sv
`timescale 1ns / 1ps
package mpfb_pkg;

  localparam int unsigned FB_WIDTH  = 128;
  localparam int unsigned FB_HEIGHT = 32;
  localparam int unsigned FB_BYTES  = FB_WIDTH * FB_HEIGHT / 8;
  localparam int unsigned ADDR_W    = $clog2(FB_BYTES);
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned REM_CNT_W = 5;

  localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
  localparam logic [5:0] PANEL_HEIGHT_RST = 6'd32;

  typedef enum logic [2:0] {
    KIND_PLOT   = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_BITMAP = 3'd2,
    KIND_NEWLN  = 3'd3,
    KIND_SETCUR = 3'd4,
    KIND_CLEAR  = 3'd5,
    KIND_READ   = 3'd6,
    KIND_NONE   = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PANEL_WIDTH  = 2'd0,
    CFG_PANEL_HEIGHT = 2'd1,
    CFG_MIRROR       = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_PIX,
    ST_WR,
    ST_ADV,
    ST_MOD,
    ST_RD
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

FILE: rtl/mpfb_ram.sv
`timescale 1ns / 1ps
module mpfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mpfb_rem.sv
`timescale 1ns / 1ps
module mpfb_rem (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [mpfb_pkg::COORD_W-1:0]       dividend_i,
  input  logic [mpfb_pkg::ROW_W-1:0]         divisor_i,
  output mpfb_pkg::rem_status_t              status_o,
  output logic [mpfb_pkg::ROW_W-1:0]         rem_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [mpfb_pkg::REM_CNT_W-1:0]     cnt_q, cnt_d;
  logic [mpfb_pkg::COORD_W-1:0]       dvd_q, dvd_d;
  logic [mpfb_pkg::ROW_W-1:0]         div_q, div_d;
  logic [mpfb_pkg::ROW_W-1:0]         rem_q, rem_d;
  logic [mpfb_pkg::ROW_W:0]           trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[mpfb_pkg::COORD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mpfb_pkg::REM_CNT_W'(mpfb_pkg::COORD_W - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = mpfb_pkg::ROW_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = mpfb_pkg::ROW_W'(trial);
      end
      dvd_d = {dvd_q[mpfb_pkg::COORD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

FILE: rtl/mono_page_framebuffer_text_render.sv
`timescale 1ns / 1ps
// Monochrome page-mode framebuffer with pixel plot, glyph blit and byte read-out.
// Requests enter on the valid/ready input channel; a read request returns one
// result on the valid/ready output channel, all other requests return nothing.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i at
// any edge and are used from then on, also by a request in progress.
// One request is handled at a time and in_ready_o is high only while idle.
// Every pixel is a read-modify-write of the frame store through its single
// port, read in ST_PIX and written in ST_WR; a bitmap pixel first passes ST_BIT.
// A cursor wrap past the panel height runs the remainder unit in ST_MOD.
// Newline, set cursor and a header with nonzero width and height are done in
// ST_IDLE. A read starts the store read in ST_IDLE and loads the output
// register in ST_RD. A clear writes zero to the store one byte per cycle.
// After reset the same clearing pass runs before the first request is taken.
// The result waits in the output register while the receiver stalls; a further
// read request waits for it in ST_RD and blocks later ones; others proceed.
module mono_page_framebuffer_text_render (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      kind_i,
  input  logic [7:0]                      pos_x_i,
  input  logic [7:0]                      pos_y_i,
  input  logic                            pixel_on_i,
  input  logic [7:0]                      glyph_width_i,
  input  logic [7:0]                      glyph_height_i,
  input  logic signed [7:0]               offset_x_i,
  input  logic signed [7:0]               offset_y_i,
  input  logic [7:0]                      advance_x_i,
  input  logic [7:0]                      advance_y_i,
  input  logic [7:0]                      bitmap_byte_i,
  input  logic [8:0]                      read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      read_data_o,
  output logic [8:0]                      read_addr_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [7:0]                      cfg_wdata_i
);

  localparam int unsigned AW = mpfb_pkg::ADDR_W;
  localparam int unsigned CW = mpfb_pkg::COORD_W;

  mpfb_pkg::state_e state_q, state_d;

  logic [7:0]    pw_q;
  logic [5:0]    ph_q;
  logic          mirror_q;

  logic [CW-1:0] cur_col_q, cur_row_q;
  logic [7:0]    g_w_q, g_h_q, g_advx_q, g_advy_q;
  logic [7:0]    g_offx_q, g_offy_q;
  logic [7:0]    g_col_q, g_row_q;

  logic [7:0]    bits_q;
  logic [2:0]    bit_idx_q;
  logic          glyph_mode_q;
  logic [CW-1:0] px_q, py_q;
  logic          on_q;
  logic [AW-1:0] addr_q;
  logic          ok_q;
  logic [7:0]    mask_q;
  logic [AW-1:0] clr_q;
  logic [8:0]    rd_idx_q;
  logic          rd_in_range_q;

  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic [8:0]    out_addr_q;

  logic          accept;
  logic          out_free;
  mpfb_pkg::kind_e kind;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          rem_start;
  mpfb_pkg::rem_status_t rem_status;
  logic [5:0]    rem_val;

  logic          pending;
  logic          bit_val;
  logic [CW-1:0] gx, gy;

  logic          x_ok, y_ok;
  logic [7:0]    xm;
  logic [5:0]    ym;
  logic [mpfb_pkg::IDX_W-1:0] pidx;
  logic          pix_ok;

  logic [7:0]    col_next;
  logic          row_done;
  logic          glyph_done;

  logic [CW-1:0] adv_col, adv_row;
  logic          adv_wrap, adv_mod;

  assign kind     = mpfb_pkg::kind_e'(kind_i);
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign pending  = g_row_q < g_h_q;
  assign bit_val  = bits_q[bit_idx_q];

  assign gx = CW'(g_col_q) + cur_col_q + {{(CW-8){g_offx_q[7]}}, g_offx_q};
  assign gy = CW'(g_row_q) + cur_row_q + {{(CW-8){g_offy_q[7]}}, g_offy_q}
              + CW'(g_advy_q);

  always_comb begin
    x_ok = px_q < CW'(pw_q);
    y_ok = py_q < CW'(ph_q);
    if (mirror_q) begin
      xm = pw_q - 8'd1 - px_q[7:0];
      ym = ph_q - 6'd1 - py_q[5:0];
    end else begin
      xm = px_q[7:0];
      ym = py_q[5:0];
    end
    pidx   = mpfb_pkg::IDX_W'(xm)
             + mpfb_pkg::IDX_W'(ym[5:3]) * mpfb_pkg::IDX_W'(pw_q);
    pix_ok = x_ok && y_ok && (pidx < mpfb_pkg::IDX_W'(mpfb_pkg::FB_BYTES));
  end

  assign col_next   = g_col_q + 8'd1;
  assign row_done   = col_next >= g_w_q;
  assign glyph_done = row_done && ((g_row_q + 8'd1) >= g_h_q);

  always_comb begin
    adv_col  = cur_col_q + CW'(g_advx_q);
    adv_row  = cur_row_q;
    adv_wrap = adv_col >= CW'(pw_q);
    adv_mod  = 1'b0;
    if (adv_wrap) begin
      adv_col = '0;
      adv_row = cur_row_q + CW'(g_advy_q);
      if (adv_row >= CW'(ph_q)) begin
        if (ph_q == '0) begin
          adv_row = '0;
        end else begin
          adv_mod = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpfb_pkg::ST_CLEAR: begin
        if (clr_q == AW'(mpfb_pkg::FB_BYTES - 1)) begin
          state_d = mpfb_pkg::ST_IDLE;
        end
      end
      mpfb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            mpfb_pkg::KIND_PLOT: state_d = mpfb_pkg::ST_PIX;
            mpfb_pkg::KIND_HEADER: begin
              if (glyph_width_i == '0 || glyph_height_i == '0) begin
                state_d = mpfb_pkg::ST_ADV;
              end
            end
            mpfb_pkg::KIND_BITMAP: begin
              if (g_w_q != '0) begin
                state_d = mpfb_pkg::ST_BIT;
              end
            end
            mpfb_pkg::KIND_CLEAR: state_d = mpfb_pkg::ST_CLEAR;
            mpfb_pkg::KIND_READ:  state_d = mpfb_pkg::ST_RD;
            default:              state_d = mpfb_pkg::ST_IDLE;
          endcase
        end
      end
      mpfb_pkg::ST_BIT: begin
        state_d = pending ? mpfb_pkg::ST_PIX : mpfb_pkg::ST_IDLE;
      end
      mpfb_pkg::ST_PIX: state_d = mpfb_pkg::ST_WR;
      mpfb_pkg::ST_WR: begin
        priority if (!glyph_mode_q) begin
          state_d = mpfb_pkg::ST_IDLE;
        end else if (glyph_done) begin
          state_d = mpfb_pkg::ST_ADV;
        end else if (bit_idx_q == '0) begin
          state_d = mpfb_pkg::ST_IDLE;
        end else begin
          state_d = mpfb_pkg::ST_BIT;
        end
      end
      mpfb_pkg::ST_ADV: state_d = adv_mod ? mpfb_pkg::ST_MOD : mpfb_pkg::ST_IDLE;
      mpfb_pkg::ST_MOD: begin
        if (rem_status.done) begin
          state_d = mpfb_pkg::ST_IDLE;
        end
      end
      mpfb_pkg::ST_RD: begin
        if (out_free) begin
          state_d = mpfb_pkg::ST_IDLE;
        end
      end
      default: state_d = mpfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = addr_q;
    ram_wdata  = on_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);
    rem_start  = 1'b0;
    unique case (state_q)
      mpfb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      mpfb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i && (kind == mpfb_pkg::KIND_READ);
        ram_addr   = AW'(read_index_i);
      end
      mpfb_pkg::ST_PIX: begin
        ram_re   = 1'b1;
        ram_addr = AW'(pidx);
      end
      mpfb_pkg::ST_WR:  ram_we    = ok_q;
      mpfb_pkg::ST_ADV: rem_start = adv_mod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpfb_pkg::ST_CLEAR;
      pw_q        <= mpfb_pkg::PANEL_WIDTH_RST;
      ph_q        <= mpfb_pkg::PANEL_HEIGHT_RST;
      mirror_q    <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      g_w_q       <= '0;
      g_h_q       <= '0;
      g_advx_q    <= '0;
      g_advy_q    <= '0;
      g_offx_q    <= '0;
      g_offy_q    <= '0;
      g_col_q     <= '0;
      g_row_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (mpfb_pkg::cfg_idx_e'(cfg_idx_i))
          mpfb_pkg::CFG_PANEL_WIDTH:  pw_q     <= cfg_wdata_i;
          mpfb_pkg::CFG_PANEL_HEIGHT: ph_q     <= cfg_wdata_i[5:0];
          mpfb_pkg::CFG_MIRROR:       mirror_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != mpfb_pkg::ST_RD) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        mpfb_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        mpfb_pkg::ST_IDLE: begin
          clr_q <= '0;
          if (accept) begin
            unique case (kind)
              mpfb_pkg::KIND_HEADER: begin
                g_w_q    <= glyph_width_i;
                g_h_q    <= glyph_height_i;
                g_offx_q <= offset_x_i;
                g_offy_q <= offset_y_i;
                g_advx_q <= advance_x_i;
                g_advy_q <= advance_y_i;
                g_col_q  <= '0;
                if (glyph_width_i == '0 || glyph_height_i == '0) begin
                  g_row_q <= glyph_height_i;
                end else begin
                  g_row_q <= '0;
                end
              end
              mpfb_pkg::KIND_NEWLN: begin
                cur_col_q <= '0;
                cur_row_q <= cur_row_q + CW'(advance_y_i);
              end
              mpfb_pkg::KIND_SETCUR: begin
                cur_col_q <= CW'(pos_x_i);
                cur_row_q <= CW'(pos_y_i);
              end
              default: ;
            endcase
          end
        end
        mpfb_pkg::ST_WR: begin
          if (glyph_mode_q) begin
            if (row_done) begin
              g_col_q <= '0;
              g_row_q <= g_row_q + 8'd1;
            end else begin
              g_col_q <= col_next;
            end
          end
        end
        mpfb_pkg::ST_ADV: begin
          cur_col_q <= adv_col;
          cur_row_q <= adv_row;
        end
        mpfb_pkg::ST_MOD: begin
          if (rem_status.done) begin
            cur_row_q <= CW'(rem_val);
          end
        end
        mpfb_pkg::ST_RD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mpfb_pkg::ST_IDLE: begin
        bits_q        <= bitmap_byte_i;
        bit_idx_q     <= 3'd7;
        glyph_mode_q  <= kind != mpfb_pkg::KIND_PLOT;
        px_q          <= CW'(pos_x_i);
        py_q          <= CW'(pos_y_i);
        on_q          <= pixel_on_i;
        rd_idx_q      <= read_index_i;
        rd_in_range_q <= 32'(read_index_i) < mpfb_pkg::FB_BYTES;
      end
      mpfb_pkg::ST_BIT: begin
        px_q <= gx;
        py_q <= gy;
        on_q <= bit_val;
      end
      mpfb_pkg::ST_PIX: begin
        addr_q <= AW'(pidx);
        ok_q   <= pix_ok;
        mask_q <= 8'(1) << ym[2:0];
      end
      mpfb_pkg::ST_WR: bit_idx_q <= bit_idx_q - 3'd1;
      mpfb_pkg::ST_RD: begin
        if (out_free) begin
          out_data_q <= rd_in_range_q ? ram_rdata : '0;
          out_addr_q <= rd_idx_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign read_addr_o = out_addr_q;

  mpfb_ram #(
    .Width(8),
    .Depth(mpfb_pkg::FB_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  mpfb_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (adv_row),
    .divisor_i  (ph_q),
    .status_o   (rem_status),
    .rem_o      (rem_val)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpfb_pkg::ST_IDLE |-> !ram_we)
    else $error("store written while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_status.busy |-> state_q == mpfb_pkg::ST_MOD)
    else $error("remainder unit busy outside wrap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_row_q <= g_h_q)
    else $error("glyph row ran past glyph height");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpfb_pkg::ST_RD && !out_free |=> $stable(out_data_q))
    else $error("pending result changed under stall");

endmodule

FILE: tb/fb_checker.sv
`timescale 1ns / 1ps
module fb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic        pixel_on_i,
  input  logic [7:0]  glyph_width_i,
  input  logic [7:0]  glyph_height_i,
  input  logic [7:0]  offset_x_i,
  input  logic [7:0]  offset_y_i,
  input  logic [7:0]  advance_x_i,
  input  logic [7:0]  advance_y_i,
  input  logic [7:0]  bitmap_byte_i,
  input  logic [8:0]  read_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  read_data_i,
  input  logic [8:0]  read_addr_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic [8:0] addr;
  } readout_t;

  logic [7:0]  shadow_fb [mpfb_pkg::FB_BYTES];
  logic [15:0] cur_col, cur_row, g_offx, g_offy;
  logic [7:0]  g_w, g_h, g_advx, g_advy, g_col, g_row;
  logic [7:0]  p_width;
  logic [5:0]  p_height;
  logic        p_mirror;
  readout_t    readout_q[$];

  assign pending_o = readout_q.size();

  task automatic put_px(input logic [15:0] x, input logic [15:0] y, input logic on);
    int unsigned idx;
    logic [15:0] xx, yy;
    xx = x;
    yy = y;
    if (xx >= p_width || yy >= p_height) return;
    if (p_mirror) begin
      xx = 16'(p_width - 1) - xx;
      yy = 16'(p_height - 1) - yy;
    end
    idx = xx + (yy / 8) * p_width;
    if (idx >= mpfb_pkg::FB_BYTES) return;
    shadow_fb[idx][yy % 8] = on;
  endtask

  task automatic advance_cur();
    cur_col = cur_col + g_advx;
    if (cur_col >= p_width) begin
      cur_row = cur_row + g_advy;
      if (cur_row >= p_height) cur_row = (p_height != 0) ? cur_row % p_height : 16'd0;
      cur_col = 0;
    end
  endtask

  task automatic predict_request();
    readout_t r;
    case (mpfb_pkg::kind_e'(kind_i))
      mpfb_pkg::KIND_PLOT: put_px({8'd0, pos_x_i}, {8'd0, pos_y_i}, pixel_on_i);
      mpfb_pkg::KIND_HEADER: begin
        g_w = glyph_width_i;
        g_h = glyph_height_i;
        g_offx = {{8{offset_x_i[7]}}, offset_x_i};
        g_offy = {{8{offset_y_i[7]}}, offset_y_i};
        g_advx = advance_x_i;
        g_advy = advance_y_i;
        g_col = 0;
        g_row = 0;
        if (g_w == 0 || g_h == 0) begin
          g_row = g_h;
          advance_cur();
        end
      end
      mpfb_pkg::KIND_BITMAP: begin
        if (g_w != 0) begin
          for (int b = 7; b >= 0; b--) begin
            if (g_row < g_h) begin
              put_px(16'(g_col) + cur_col + g_offx,
                     16'(g_row) + cur_row + g_offy + 16'(g_advy), bitmap_byte_i[b]);
              g_col++;
              if (g_col >= g_w) begin
                g_col = 0;
                g_row++;
                if (g_row >= g_h) advance_cur();
              end
            end
          end
        end
      end
      mpfb_pkg::KIND_NEWLN: begin
        cur_row = cur_row + advance_y_i;
        cur_col = 0;
      end
      mpfb_pkg::KIND_SETCUR: begin
        cur_col = {8'd0, pos_x_i};
        cur_row = {8'd0, pos_y_i};
      end
      mpfb_pkg::KIND_CLEAR: for (int i = 0; i < mpfb_pkg::FB_BYTES; i++) shadow_fb[i] = '0;
      mpfb_pkg::KIND_READ: begin
        r.addr = read_index_i;
        r.data = (read_index_i < mpfb_pkg::FB_BYTES) ? shadow_fb[read_index_i] : 8'd0;
        readout_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t e;
    if (!rst_ni) begin
      for (int i = 0; i < mpfb_pkg::FB_BYTES; i++) shadow_fb[i] = '0;
      cur_col = 0; cur_row = 0; g_offx = 0; g_offy = 0;
      g_w = 0; g_h = 0; g_advx = 0; g_advy = 0; g_col = 0; g_row = 0;
      p_width = mpfb_pkg::PANEL_WIDTH_RST;
      p_height = mpfb_pkg::PANEL_HEIGHT_RST;
      p_mirror = 0;
      readout_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (readout_q.size() == 0) begin
          $display("%0t: unexpected result data %h addr %h", $time, read_data_i, read_addr_i);
          fail_count_o++;
        end else begin
          e = readout_q.pop_front();
          if (e.data !== read_data_i) begin
            $display("%0t: read_data expected %h actual %h", $time, e.data, read_data_i);
            fail_count_o++;
          end
          if (e.addr !== read_addr_i) begin
            $display("%0t: read_addr expected %h actual %h", $time, e.addr, read_addr_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_request();
      if (cfg_we_i) begin
        case (mpfb_pkg::cfg_idx_e'(cfg_idx_i))
          mpfb_pkg::CFG_PANEL_WIDTH:  p_width = cfg_wdata_i;
          mpfb_pkg::CFG_PANEL_HEIGHT: p_height = cfg_wdata_i[5:0];
          mpfb_pkg::CFG_MIRROR:       p_mirror = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic [2:0] kind_i = 0;
  logic [7:0] pos_x_i = 0, pos_y_i = 0, glyph_width_i = 0, glyph_height_i = 0;
  logic [7:0] offset_x_i = 0, offset_y_i = 0, advance_x_i = 0, advance_y_i = 0;
  logic [7:0] bitmap_byte_i = 0, read_data_o, cfg_wdata_i = 0;
  logic pixel_on_i = 0, cfg_we_i = 0;
  logic [8:0] read_index_i = 0, read_addr_o;
  logic [1:0] cfg_idx_i = 0;
  int fails, pending;
  bit calm = 0;

  always #4 clk_i = ~clk_i;

  mono_page_framebuffer_text_render uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .pos_x_i, .pos_y_i,
    .pixel_on_i, .glyph_width_i, .glyph_height_i,
    .offset_x_i(signed'(offset_x_i)), .offset_y_i(signed'(offset_y_i)),
    .advance_x_i, .advance_y_i, .bitmap_byte_i, .read_index_i, .out_valid_o,
    .out_ready_i, .read_data_o, .read_addr_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i);

  fb_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .pos_x_i,
    .pos_y_i, .pixel_on_i, .glyph_width_i, .glyph_height_i, .offset_x_i,
    .offset_y_i, .advance_x_i, .advance_y_i, .bitmap_byte_i, .read_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .read_data_i(read_data_o),
    .read_addr_i(read_addr_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fails), .pending_o(pending));

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  task automatic send(input logic [2:0] k, input logic [7:0] a, input logic [7:0] b,
                      input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                      input logic [7:0] f, input logic [7:0] g, input logic [8:0] r,
                      input logic on);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    kind_i <= k; pos_x_i <= a; pos_y_i <= b; glyph_width_i <= a; glyph_height_i <= b;
    offset_x_i <= c; offset_y_i <= d; advance_x_i <= e; advance_y_i <= f;
    bitmap_byte_i <= g; read_index_i <= r; pixel_on_i <= on;
    in_valid_i <= 1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_in();
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic rnd_item(input logic [2:0] k);
    send(k, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
         8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
  endtask

  task automatic read_at(input logic [8:0] r);
    send(mpfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, r, 0);
  endtask

  task automatic settle_and_cfg(input logic [7:0] w, input logic [5:0] h, input logic m);
    idle_in();
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= mpfb_pkg::CFG_PANEL_WIDTH; cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= mpfb_pkg::CFG_PANEL_HEIGHT; cfg_wdata_i <= {2'b0, h};
    @(posedge clk_i);
    cfg_idx_i <= mpfb_pkg::CFG_MIRROR; cfg_wdata_i <= {7'b0, m};
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic glyph_seq();
    int w, h, nb;
    w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 12);
    h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 12);
    if ($urandom_range(0, 7) == 0) rnd_item(mpfb_pkg::KIND_SETCUR);
    send(mpfb_pkg::KIND_HEADER, 8'(w), 8'(h),
         $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4),
         $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 8) - 4),
         8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)), 0, 0, 0);
    nb = (w * h + 7) / 8;
    if (nb > 20) nb = $urandom_range(1, 20);
    if ($urandom_range(0, 5) == 0) nb = nb - $urandom_range(0, nb);
    for (int i = 0; i < nb; i++) begin
      rnd_item(mpfb_pkg::KIND_BITMAP);
      if ($urandom_range(0, 9) == 0) begin
        rnd_item($urandom_range(0, 1) ? mpfb_pkg::KIND_PLOT : mpfb_pkg::KIND_NEWLN);
      end
    end
    repeat ($urandom_range(0, 3)) read_at(9'($urandom_range(0, 520)));
  endtask

  initial begin
    int cnt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    send(mpfb_pkg::KIND_PLOT, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send(mpfb_pkg::KIND_PLOT, 127, 31, 0, 0, 0, 0, 0, 0, 1);
    send(mpfb_pkg::KIND_PLOT, 255, 255, 0, 0, 0, 0, 0, 0, 1);
    read_at(0); read_at(511); read_at(385 + 126);
    send(mpfb_pkg::KIND_HEADER, 8, 2, 8'h80, 8'h7f, 3, 0, 0, 0, 0);
    send(mpfb_pkg::KIND_HEADER, 3, 3, 8'hff, 8'hfe, 255, 255, 0, 0, 0);
    send(mpfb_pkg::KIND_BITMAP, 0, 0, 0, 0, 0, 0, 8'hff, 0, 0);
    send(mpfb_pkg::KIND_BITMAP, 0, 0, 0, 0, 0, 0, 8'h80, 0, 0);
    send(mpfb_pkg::KIND_BITMAP, 0, 0, 0, 0, 0, 0, 8'h55, 0, 0);
    send(mpfb_pkg::KIND_HEADER, 0, 5, 0, 0, 200, 9, 0, 0, 0);
    send(mpfb_pkg::KIND_HEADER, 5, 0, 0, 0, 200, 9, 0, 0, 0);
    send(mpfb_pkg::KIND_NEWLN, 0, 0, 0, 0, 0, 255, 0, 0, 0);
    send(mpfb_pkg::KIND_SETCUR, 255, 255, 0, 0, 0, 0, 0, 0, 0);
    send(mpfb_pkg::KIND_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    read_at(1); read_at(128);
    send(mpfb_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    read_at(0); read_at(511);
    idle_in();
    while (pending != 0) @(posedge clk_i);
    settle_and_cfg(0, 0, 1);
    send(mpfb_pkg::KIND_PLOT, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send(mpfb_pkg::KIND_HEADER, 0, 0, 0, 0, 5, 5, 0, 0, 0);
    read_at(0);
    cnt = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: settle_and_cfg(128, 32, 0);
        1: settle_and_cfg(1, 8, 1);
        2: settle_and_cfg(255, 63, 1);
        3: settle_and_cfg(8'($urandom_range(1, 128)), 6'($urandom_range(8, 32)),
                          1'($urandom));
        4: settle_and_cfg(128, 32, 1);
        default: settle_and_cfg(8'($urandom_range(1, 128)), 6'($urandom_range(8, 32)), 0);
      endcase
      if (ph == 5) calm = 1;
      while (cnt < (ph + 1) * 170) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: glyph_seq();
          8, 9, 10: rnd_item(mpfb_pkg::KIND_PLOT);
          11, 12, 13, 14: read_at(9'($urandom));
          15: rnd_item(mpfb_pkg::KIND_NEWLN);
          16: rnd_item(mpfb_pkg::KIND_SETCUR);
          17: rnd_item(3'($urandom_range(0, 7)));
          18: if ($urandom_range(0, 9) == 0) rnd_item(mpfb_pkg::KIND_CLEAR);
          default: read_at(9'($urandom_range(0, 140)));
        endcase
        cnt += 4;
      end
      idle_in();
      while (pending != 0) @(posedge clk_i);
    end
    for (int i = 0; i < 16; i++) read_at(9'(i * 32));
    idle_in();
    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mpfb_pkg.sv
rtl/mpfb_ram.sv
rtl/mpfb_rem.sv
rtl/mono_page_framebuffer_text_render.sv
tb/fb_checker.sv
tb/tb.sv
